@@ sv/bhq_pkg.sv @@
// Package for the binary min-heap queue: key, status and opcode types and codes.
// No dependencies; bhq_if, the heap queue unit and its testbench import it.
package bhq_pkg;

	localparam int KEY_W    = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [COUNT_W-1:0]      count_t;
	typedef logic [STATUS_W-1:0]     status_t;
	typedef logic                    op_t;

	// Operation codes carried in the op field of an input word.
	localparam op_t OP_INSERT  = 1'b0;
	localparam op_t OP_EXTRACT = 1'b1;

	// Status codes of a result word.
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_EMPTY = 2'd2;

endpackage

@@ sv/bhq_if.sv @@
// Valid/ready channel interfaces of the heap queue: request and response words.
// Depends on bhq_pkg for the field types.
interface bhq_req_if import bhq_pkg::*; ();
	logic valid;
	logic ready;
	op_t  op;
	key_t key_in;

	modport source (output valid, output op, output key_in, input ready);
	modport sink (input valid, input op, input key_in, output ready);
endinterface

interface bhq_rsp_if import bhq_pkg::*; ();
	logic    valid;
	logic    ready;
	key_t    extracted;
	key_t    current_min;
	count_t  count;
	status_t status;

	modport source (output valid, output extracted, output current_min, output count,
		output status, input ready);
	modport sink (input valid, input extracted, input current_min, input count,
		input status, output ready);
endinterface

@@ sv/bhq_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module bhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/binary_min_heap_queue_unit.sv @@
// Binary min-heap priority queue of signed keys, held in one synchronous RAM.
// Depends on bhq_pkg, bhq_if (bhq_req_if, bhq_rsp_if) and bhq_ram.
//
//   channel | dir | word fields                              | one word means
//   --------+-----+------------------------------------------+------------------------
//   req     | in  | op, key_in                               | insert or extract-min
//   rsp     | out | extracted, current_min, count, status    | result of one request
//
// An insert sifts the new key up and an extract sifts the last key down by L levels, where
// L is at most log2(CAPACITY); a refused request, an insert into an empty heap and the
// extract of the only key need no sift at all.
// The heap RAM has a single read port, so sift-down reads both children in turn.
// A finished word waits in the output register; a new request is taken while it waits.
// Reset empties the heap at once; RAM contents are not cleared and need no sweep.
module binary_min_heap_queue_unit import bhq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	bhq_req_if.sink   req,
	bhq_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_UP     = 3'd1;
	localparam logic [2:0] S_LAST   = 3'd2;
	localparam logic [2:0] S_DN_L   = 3'd3;
	localparam logic [2:0] S_DN_R   = 3'd4;
	localparam logic [2:0] S_WR_KEY = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] pos_q, pos_d;
	key_t          key_q, key_d;
	key_t          left_q, left_d;
	key_t          root_q;
	key_t          taken_q, taken_d;
	status_t       status_q, status_d;

	logic          rsp_valid_q;
	key_t          rsp_extracted_q;
	key_t          rsp_min_q;
	count_t        rsp_count_q;
	status_t       rsp_status_q;

	logic          we;
	logic [AW-1:0] waddr;
	key_t          wdata;
	logic [AW-1:0] raddr;
	logic [KEY_W-1:0] rdata;
	key_t          rd_key;

	logic          fin_load;
	logic          dn_go;
	logic          dn_use_r;
	key_t          dn_child;
	logic [AW-1:0] dn_best;
	logic [IW-1:0] lc, rc, nlc, count_ext;
	logic [AW-1:0] up_pos, ins_pos, ins_up;
	logic [CW-1:0] cm1;
	logic          full, accept;

	// Heap storage.
	bhq_ram #(
		.WIDTH(KEY_W),
		.DEPTH(CAPACITY)
	) u_heap_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_key = $signed(rdata);

	// Index arithmetic for parent and children.
	assign count_ext = IW'(count_q);
	assign lc        = {1'b0, pos_q, 1'b1};
	assign rc        = lc + IW'(1);
	assign up_pos    = AW'((pos_q - AW'(1)) >> 1);
	assign ins_pos   = count_q[AW-1:0];
	assign ins_up    = AW'((ins_pos - AW'(1)) >> 1);
	assign cm1       = count_q - CW'(1);
	assign full      = (count_q == CW'(CAPACITY));
	assign accept    = req.valid && req.ready;

	// Choice of the smaller child; the left child wins ties.
	assign dn_use_r  = (state_q == S_DN_R) && (rd_key < left_q);
	assign dn_child  = (state_q == S_DN_R && !dn_use_r) ? left_q : rd_key;
	assign dn_best   = dn_use_r ? rc[AW-1:0] : lc[AW-1:0];
	assign nlc       = {1'b0, dn_best, 1'b1};

	// Sequencer: one heap access pattern per state.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		pos_d    = pos_q;
		key_d    = key_q;
		left_d   = left_q;
		taken_d  = taken_q;
		status_d = status_q;
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = key_q;
		raddr    = up_pos;
		req.ready = 1'b0;
		fin_load = 1'b0;
		dn_go    = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					taken_d  = '0;
					status_d = STATUS_OK;
					key_d    = req.key_in;
					state_d  = S_FIN;
					if (req.op == OP_INSERT) begin
						if (full) begin
							status_d = STATUS_FULL;
						end else begin
							count_d = count_q + CW'(1);
							pos_d   = ins_pos;
							if (count_q == '0) begin
								we    = 1'b1;
								waddr = '0;
								wdata = req.key_in;
							end else begin
								raddr   = ins_up;
								state_d = S_UP;
							end
						end
					end else begin
						if (count_q == '0) begin
							status_d = STATUS_EMPTY;
						end else begin
							taken_d = root_q;
							count_d = cm1;
							if (count_q != CW'(1)) begin
								raddr   = cm1[AW-1:0];
								state_d = S_LAST;
							end
						end
					end
				end
			end
			S_UP: begin
				if (key_q < rd_key) begin
					we    = 1'b1;
					wdata = rd_key;
					pos_d = up_pos;
					if (up_pos == '0) begin
						state_d = S_WR_KEY;
					end else begin
						raddr = AW'((up_pos - AW'(1)) >> 1);
					end
				end else begin
					we      = 1'b1;
					state_d = S_FIN;
				end
			end
			S_LAST: begin
				// The last key becomes the new root and, if the root has a child, starts its way down.
				key_d = rd_key;
				pos_d = '0;
				raddr = AW'(1);
				if (count_q >= CW'(2)) begin
					state_d = S_DN_L;
				end else begin
					state_d = S_WR_KEY;
				end
			end
			S_DN_L: begin
				if (rc < count_ext) begin
					left_d  = rd_key;
					raddr   = rc[AW-1:0];
					state_d = S_DN_R;
				end else begin
					dn_go = 1'b1;
				end
			end
			S_DN_R: begin
				dn_go = 1'b1;
			end
			S_WR_KEY: begin
				we      = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp.ready) begin
					fin_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// One sift-down level: move the smaller child up or settle the key here.
		if (dn_go) begin
			we = 1'b1;
			if (dn_child < key_q) begin
				wdata = dn_child;
				pos_d = dn_best;
				if (nlc < count_ext) begin
					raddr   = nlc[AW-1:0];
					state_d = S_DN_L;
				end else begin
					state_d = S_WR_KEY;
				end
			end else begin
				state_d = S_FIN;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (fin_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers, root copy and output word.
	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		key_q    <= key_d;
		left_q   <= left_d;
		taken_q  <= taken_d;
		status_q <= status_d;
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
		if (fin_load) begin
			rsp_extracted_q <= taken_q;
			rsp_min_q       <= (count_q != '0) ? root_q : '0;
			rsp_count_q     <= COUNT_W'(count_q);
			rsp_status_q    <= status_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.extracted   = rsp_extracted_q;
	assign rsp.current_min = rsp_min_q;
	assign rsp.count       = rsp_count_q;
	assign rsp.status      = rsp_status_q;

	// The heap never holds more keys than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("heap count above capacity");

	// Writes land only inside the occupied region or on the slot being filled.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> CW'(waddr) <= count_q)
		else $error("heap write beyond occupied slots");

	// An extract from an empty heap is refused and leaves it empty.
	a_empty_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.op == OP_EXTRACT && count_q == '0)
		|=> (count_q == '0 && status_q == STATUS_EMPTY))
		else $error("extract from empty heap not refused");

	// An accepted request always moves the sequencer out of the idle state.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted without being processed");

endmodule

@@ tb/binary_min_heap_queue_unit_test.sv @@
// Self-checking testbench for binary_min_heap_queue_unit: a table of directed words,
// then phased random fill, drain and mixed traffic, checked against typed results or a heap predictor.
// Depends on bhq_pkg, bhq_if and the block's RTL; reads no files.
module binary_min_heap_queue_unit_test import bhq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP_DEPTH     = 64;
	localparam int ITEM_TARGET    = 1450;
	localparam int IDLE_PCT       = 29;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;

	localparam key_t KEY_MAX = 32'sh7FFFFFFF;
	localparam key_t KEY_MIN = 32'sh80000000;

	typedef struct packed {
		key_t    extracted;
		key_t    current_min;
		count_t  count;
		status_t status;
	} heap_result_t;

	typedef struct packed {
		op_t          op;
		key_t         key;
		bit           typed;
		heap_result_t want;
	} stim_row_t;

	localparam heap_result_t NO_RESULT = '0;
	localparam int DIRECTED_ROWS = 24;

	// Directed words; typed results only where they are plain, the rest go to the predictor.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_EXTRACT, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 7'd0, STATUS_EMPTY}},
		'{OP_INSERT, KEY_MAX, 1'b1, '{32'sd0, KEY_MAX, 7'd1, STATUS_OK}},
		'{OP_INSERT, KEY_MIN, 1'b1, '{32'sd0, KEY_MIN, 7'd2, STATUS_OK}},
		'{OP_INSERT, 32'sd0, 1'b0, NO_RESULT},
		'{OP_INSERT, -32'sd1, 1'b0, NO_RESULT},
		'{OP_INSERT, 32'sd5, 1'b0, NO_RESULT},
		'{OP_INSERT, 32'sd5, 1'b0, NO_RESULT},
		'{OP_INSERT, -32'sd1, 1'b0, NO_RESULT},
		'{OP_INSERT, 32'sh55555555, 1'b0, NO_RESULT},
		'{OP_INSERT, 32'shAAAAAAAA, 1'b0, NO_RESULT},
		'{OP_INSERT, KEY_MIN, 1'b0, NO_RESULT},
		'{OP_EXTRACT, KEY_MAX, 1'b0, NO_RESULT},
		'{OP_EXTRACT, -32'sd1, 1'b0, NO_RESULT},
		'{OP_EXTRACT, KEY_MIN, 1'b0, NO_RESULT},
		'{OP_EXTRACT, 32'sh55555555, 1'b0, NO_RESULT},
		'{OP_EXTRACT, 32'shAAAAAAAA, 1'b0, NO_RESULT},
		'{OP_EXTRACT, KEY_MAX, 1'b0, NO_RESULT},
		'{OP_EXTRACT, -32'sd1, 1'b0, NO_RESULT},
		'{OP_EXTRACT, 32'sd0, 1'b0, NO_RESULT},
		'{OP_EXTRACT, KEY_MAX, 1'b0, NO_RESULT},
		'{OP_EXTRACT, 32'sd7, 1'b0, NO_RESULT},
		'{OP_EXTRACT, KEY_MAX, 1'b1, '{32'sd0, 32'sd0, 7'd0, STATUS_EMPTY}},
		'{OP_INSERT, KEY_MAX, 1'b1, '{32'sd0, KEY_MAX, 7'd1, STATUS_OK}},
		'{OP_EXTRACT, 32'sd0, 1'b1, '{KEY_MAX, 32'sd0, 7'd0, STATUS_OK}}
	};

	logic clk;
	logic arst_n;

	bhq_req_if req_ch ();
	bhq_rsp_if rsp_ch ();

	binary_min_heap_queue_unit #(.CAPACITY(HEAP_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predictor state: the heap as the block should hold it.
	key_t heap_model [HEAP_DEPTH];
	int   model_count;

	heap_result_t expected_results [$];
	heap_result_t oldest_expected;
	int           mismatch_count;
	int           items_sent;
	int           quiet_cycles;
	bit           idle_on;
	bit           hold_request;
	int           hold_left;

	always #5 clk = ~clk;

	// Apply one request to the predicted heap and return the word it should produce.
	function automatic heap_result_t apply_request(op_t op, key_t key);
		heap_result_t res;
		int           pos;
		int           up;
		int           lc;
		int           rc;
		int           best;
		key_t         tmp;
		res = '0;
		if (op == OP_INSERT) begin
			if (model_count >= HEAP_DEPTH) begin
				res.status = STATUS_FULL;
			end else begin
				// Sift up: move parents down while they are strictly larger.
				pos = model_count;
				model_count++;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (!(key < heap_model[up]))
						break;
					heap_model[pos] = heap_model[up];
					pos = up;
				end
				heap_model[pos] = key;
				res.status = STATUS_OK;
			end
		end else begin
			if (model_count == 0) begin
				res.status = STATUS_EMPTY;
			end else begin
				res.extracted = heap_model[0];
				heap_model[0] = heap_model[model_count-1];
				model_count--;
				// Sift down toward the smaller child; the left child wins a tie.
				pos = 0;
				forever begin
					lc = 2 * pos + 1;
					rc = lc + 1;
					best = pos;
					if (lc < model_count && heap_model[lc] < heap_model[best])
						best = lc;
					if (rc < model_count && heap_model[rc] < heap_model[best])
						best = rc;
					if (best == pos)
						break;
					tmp = heap_model[pos];
					heap_model[pos] = heap_model[best];
					heap_model[best] = tmp;
					pos = best;
				end
				res.status = STATUS_OK;
			end
		end
		res.current_min = (model_count > 0) ? heap_model[0] : '0;
		res.count = count_t'(model_count);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// Offer one request word, wait for the handshake, then record what it should return.
	task automatic send_word(op_t op, key_t key, bit typed, heap_result_t typed_res);
		heap_result_t predicted;
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.key_in <= key;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = apply_request(op, key);
		expected_results.push_back(typed ? typed_res : predicted);
		items_sent++;
	endtask

	// Random key: mostly full-width values, with small duplicates, extremes and keys near KEY_MIN.
	task automatic send_random(op_t op);
		key_t key;
		case ($urandom_range(9))
			6, 7: key = $signed($urandom_range(6)) - 32'sd3;
			8: begin
				case ($urandom_range(3))
					0: key = KEY_MIN;
					1: key = KEY_MAX;
					2: key = 32'sd0;
					default: key = -32'sd1;
				endcase
			end
			9: key = KEY_MIN + $signed($urandom_range(3));
			default: key = $urandom();
		endcase
		send_word(op, key, 1'b0, NO_RESULT);
	endtask

	// Stimulus: reset, directed table, then random phases.
	initial begin
		int phase_idx;
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_INSERT;
		req_ch.key_in = '0;
		model_count = 0;
		mismatch_count = 0;
		items_sent = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
				directed_rows[i].want);

		phase_idx = 0;
		while (items_sent < ITEM_TARGET) begin
			// A few phases in the middle run with no idling on either side.
			idle_on = (phase_idx < 4 || phase_idx > 6);
			case (phase_idx == 0 ? 0 : phase_idx == 1 ? 1 : $urandom_range(2))
				0: begin
					// Fill to capacity, then push a few refused inserts.
					if (phase_idx == 0)
						hold_request = 1'b1;
					while (model_count < HEAP_DEPTH)
						send_random(($urandom_range(99) < 88) ? OP_INSERT : OP_EXTRACT);
					n = $urandom_range(1, 3);
					repeat (n) send_random(OP_INSERT);
				end
				1: begin
					// Drain to empty, then a few refused extracts.
					while (model_count > 0)
						send_random(($urandom_range(99) < 88) ? OP_EXTRACT : OP_INSERT);
					n = $urandom_range(1, 3);
					repeat (n) send_random(OP_EXTRACT);
				end
				default: begin
					n = $urandom_range(20, 80);
					repeat (n) send_random($urandom_range(1) ? OP_EXTRACT : OP_INSERT);
				end
			endcase
			phase_idx++;
		end
		req_ch.valid <= 1'b0;

		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("binary_min_heap_queue_unit_test: PASS");
		else
			$display("binary_min_heap_queue_unit_test: FAIL");
		$finish;
	end

	// Result side ready: random idling, plus one long hold-off to back the block up.
	initial begin
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Check every accepted result word against the oldest expectation; watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result word with no request outstanding");
				end else begin
					oldest_expected = expected_results.pop_front();
					if (rsp_ch.extracted !== oldest_expected.extracted)
						report_mismatch($sformatf("extracted: expected %0d, got %0d",
							oldest_expected.extracted, rsp_ch.extracted));
					if (rsp_ch.current_min !== oldest_expected.current_min)
						report_mismatch($sformatf("current_min: expected %0d, got %0d",
							oldest_expected.current_min, rsp_ch.current_min));
					if (rsp_ch.count !== oldest_expected.count)
						report_mismatch($sformatf("count: expected %0d, got %0d",
							oldest_expected.count, rsp_ch.count));
					if (rsp_ch.status !== oldest_expected.status)
						report_mismatch($sformatf("status: expected %0d, got %0d",
							oldest_expected.status, rsp_ch.status));
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("ERROR @%0t: no word moved for %0d cycles, %0d results pending",
						$realtime, quiet_cycles, expected_results.size());
					$display("binary_min_heap_queue_unit_test: FAIL");
					$finish;
				end
			end
		end
	end

endmodule
